// ----- design/empr_pkg.sv -----
// Shared types and constants for the energy meter pulse packet receiver.
package empr_pkg;

	// Packet framing
	localparam int BITS_PER_PACKET = 67;
	localparam int BIT_IDX_W       = 7;
	localparam int BYTE_IDX_W      = 4;
	localparam int PKT_BYTES       = 8;
	localparam int SUM_BYTES       = 7;

	// Register map
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam logic [1:0] REG_START_THR = 2'd0;
	localparam logic [1:0] REG_BIT_MIN   = 2'd1;
	localparam logic [1:0] REG_ONE_THR   = 2'd2;
	localparam logic [1:0] REG_MAINS_V   = 2'd3;

	localparam logic [15:0] START_THR_RST = 16'd480;
	localparam logic [15:0] BIT_MIN_RST   = 16'd20;
	localparam logic [15:0] ONE_THR_RST   = 16'd85;
	localparam logic [9:0]  MAINS_V_RST   = 10'd230;

	// Decode arithmetic
	localparam int MILLI      = 1000;
	localparam int CUR_MAX    = 100000;
	localparam int EXPO_MAX   = 15;
	localparam int RECIP_SH   = 31;
	// ceil(2^31 / 125): exact quotient for any dividend below 2^24
	localparam int RECIP_125  = 17179870;

	// Packet queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [15:0] start_thr;
		logic [15:0] bit_min;
		logic [15:0] one_thr;
	} empr_thr_t;

	typedef struct packed {
		logic [PKT_BYTES-1:0][7:0] bytes;
		logic                      full_count;
	} empr_pkt_t;

	typedef struct packed {
		logic        checksum_ok;
		logic [15:0] transmitter_id;
		logic [16:0] current_ma;
		logic        current_invalid;
		logic [16:0] power_w;
		logic [4:0]  interval_s;
		logic        pairing_on;
		logic        battery_ok;
	} empr_res_t;

endpackage

// ----- design/energy_meter_pulse_packet_receiver.sv -----
// Top level of the energy meter pulse packet receiver.
//
//  port group      role                            flow control
//  ----------      ----                            ------------
//  pulse_*         one measured pulse width        pulse_valid / pulse_ready
//  result fields   one decoded packet              result_valid / result_ready
//  APB             four config registers, 4*i      psel/penable, pready tied high
//
// One pulse is taken every cycle while the two-entry packet queue has room.
// A decoded packet is queued at the transfer of its last pulse, then passes
// through four decode stages plus the output register.
// Reset is asynchronous and needs no clearing pass; the byte store is not reset.
// A stalled result holds the decode pipeline; the queue then fills and
// pulse_ready stays low for any pulse while the queue holds two packets.
module energy_meter_pulse_packet_receiver import empr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  pulse_valid,
	output logic                  pulse_ready,
	input  logic [15:0]           pulse_width_us,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  checksum_ok,
	output logic [15:0]           transmitter_id,
	output logic [16:0]           current_ma,
	output logic                  current_invalid,
	output logic [16:0]           power_w,
	output logic [4:0]            interval_s,
	output logic                  pairing_on,
	output logic                  battery_ok
);

	empr_thr_t  thr;
	logic [9:0] mains_v;
	logic       push;
	empr_pkt_t  push_pkt;
	logic       q_full;
	logic       head_valid;
	empr_pkt_t  head_pkt;
	logic       pop;
	empr_res_t  res;

	empr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr),
		.mains_v (mains_v)
	);

	empr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.thr            (thr),
		.pulse_valid    (pulse_valid),
		.pulse_ready    (pulse_ready),
		.pulse_width_us (pulse_width_us),
		.q_full         (q_full),
		.push           (push),
		.push_pkt       (push_pkt)
	);

	empr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_pkt   (push_pkt),
		.full       (q_full),
		.head_valid (head_valid),
		.head_pkt   (head_pkt),
		.pop        (pop)
	);

	empr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.mains_v      (mains_v),
		.head_valid   (head_valid),
		.head_pkt     (head_pkt),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (res)
	);

	assign checksum_ok     = res.checksum_ok;
	assign transmitter_id  = res.transmitter_id;
	assign current_ma      = res.current_ma;
	assign current_invalid = res.current_invalid;
	assign power_w         = res.power_w;
	assign interval_s      = res.interval_s;
	assign pairing_on      = res.pairing_on;
	assign battery_ok      = res.battery_ok;

endmodule

// ----- design/empr_regs.sv -----
// Configuration register file on an APB-style port.
module empr_regs import empr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output empr_thr_t             thr,
	output logic [9:0]            mains_v
);

	logic        wr_en;
	logic [1:0]  reg_sel;
	logic [15:0] start_thr_q;
	logic [15:0] bit_min_q;
	logic [15:0] one_thr_q;
	logic [9:0]  mains_v_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q <= START_THR_RST;
			bit_min_q   <= BIT_MIN_RST;
			one_thr_q   <= ONE_THR_RST;
			mains_v_q   <= MAINS_V_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_START_THR: start_thr_q <= pwdata[15:0];
				REG_BIT_MIN:   bit_min_q   <= pwdata[15:0];
				REG_ONE_THR:   one_thr_q   <= pwdata[15:0];
				REG_MAINS_V:   mains_v_q   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_START_THR: prdata = {16'd0, start_thr_q};
			REG_BIT_MIN:   prdata = {16'd0, bit_min_q};
			REG_ONE_THR:   prdata = {16'd0, one_thr_q};
			REG_MAINS_V:   prdata = {22'd0, mains_v_q};
			default:       prdata = '0;
		endcase
	end

	assign thr.start_thr = start_thr_q;
	assign thr.bit_min   = bit_min_q;
	assign thr.one_thr   = one_thr_q;
	assign mains_v       = mains_v_q;

endmodule

// ----- design/empr_front.sv -----
// Front end: classifies pulses, assembles bits into bytes, hands off whole packets.
module empr_front import empr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  empr_thr_t   thr,
	input  logic        pulse_valid,
	output logic        pulse_ready,
	input  logic [15:0] pulse_width_us,
	input  logic        q_full,
	output logic        push,
	output empr_pkt_t   push_pkt
);

	logic                  in_pkt_q;
	logic [BIT_IDX_W-1:0]  bit_idx_q;
	logic [7:0]            shift_q;
	logic [BYTE_IDX_W-1:0] byte_idx_q;
	logic [7:0]            store_q [PKT_BYTES];

	logic                  accept;
	logic                  is_start;
	logic                  is_bit;
	logic [7:0]            sh_next;
	logic [BIT_IDX_W-1:0]  bi_next;
	logic                  byte_done;
	logic                  store_wr;
	logic [BYTE_IDX_W-1:0] byte_idx_next;
	logic                  last_bit;
	logic [7:0]            store_next [PKT_BYTES];

	assign pulse_ready = ~q_full;
	assign accept      = pulse_valid & pulse_ready;

	assign is_start  = pulse_width_us > thr.start_thr;
	// a data bit: inside a packet, nonzero, not a start pulse, above the minimum
	assign is_bit    = in_pkt_q && (pulse_width_us != 16'd0) && !is_start
	                   && (pulse_width_us > thr.bit_min);
	assign sh_next   = {shift_q[6:0], pulse_width_us > thr.one_thr};
	assign bi_next   = bit_idx_q + 1'b1;
	assign byte_done = (bi_next[2:0] == 3'd0);
	assign store_wr  = is_bit && byte_done && !byte_idx_q[BYTE_IDX_W-1];
	assign byte_idx_next = (byte_done && (byte_idx_q != '1)) ? byte_idx_q + 1'b1 : byte_idx_q;
	assign last_bit  = is_bit && (bi_next >= BIT_IDX_W'(BITS_PER_PACKET));

	always_comb begin
		for (int i = 0; i < PKT_BYTES; i++) begin
			store_next[i] = (store_wr && (byte_idx_q[2:0] == 3'(i))) ? sh_next : store_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < PKT_BYTES; i++) begin
			push_pkt.bytes[i] = store_next[i];
		end
		push_pkt.full_count = (byte_idx_next == BYTE_IDX_W'(PKT_BYTES));
	end

	assign push = accept & last_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q   <= 1'b0;
			bit_idx_q  <= '0;
			shift_q    <= '0;
			byte_idx_q <= '0;
		end else if (accept) begin
			if (!in_pkt_q) begin
				if (is_start) begin
					in_pkt_q   <= 1'b1;
					bit_idx_q  <= '0;
					shift_q    <= '0;
					byte_idx_q <= '0;
				end
			end else if (pulse_width_us == 16'd0) begin
				in_pkt_q   <= 1'b0;
				bit_idx_q  <= '0;
				shift_q    <= '0;
				byte_idx_q <= '0;
			end else if (is_start) begin
				bit_idx_q  <= '0;
				shift_q    <= '0;
				byte_idx_q <= '0;
			end else if (is_bit) begin
				if (last_bit) begin
					in_pkt_q   <= 1'b0;
					bit_idx_q  <= '0;
					shift_q    <= '0;
					byte_idx_q <= '0;
				end else begin
					bit_idx_q  <= bi_next;
					shift_q    <= byte_done ? 8'd0 : sh_next;
					byte_idx_q <= byte_idx_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_wr) begin
			store_q[byte_idx_q[2:0]] <= sh_next;
		end
	end

	// packet always closes on its last bit
	a_close_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !in_pkt_q)
		else $error("packet still open after last bit");

endmodule

// ----- design/empr_queue.sv -----
// Short packet queue between the front end and the decoder.
module empr_queue import empr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  empr_pkt_t push_pkt,
	output logic      full,
	output logic      head_valid,
	output empr_pkt_t head_pkt,
	input  logic      pop
);

	empr_pkt_t         mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_pkt   = mem[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_pkt;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("packet pushed into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QDEPTH))
		else $error("queue count out of range");

endmodule

// ----- design/empr_back.sv -----
// Back end: decodes a stored packet into the result fields over a short pipeline.
module empr_back import empr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [9:0] mains_v,
	input  logic      head_valid,
	input  empr_pkt_t head_pkt,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_ready,
	output empr_res_t result
);

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4, out_valid_q;

	empr_res_t   res_s1, res_s2, res_s3, res_s4, res_q;
	empr_res_t   res_s1_next, res_s2_next, res_q_next;
	logic [25:0] prod1_s1;
	logic [7:0]  expo_s1;
	logic [26:0] prod2_s3;
	logic [48:0] prod3_s4;

	logic [7:0]  sum;
	logic        lead_ok;
	logic [15:0] mant;
	logic [4:0]  ival;
	logic [3:0]  shamt;
	logic [25:0] cur_raw;
	logic        cur_bad;
	logic [23:0] div8;

	assign adv          = ~out_valid_q | result_ready;
	assign pop          = adv & head_valid;
	assign result_valid = out_valid_q;
	assign result       = res_q;

	// stage 1 decode of the raw bytes
	always_comb begin
		sum = '0;
		for (int i = 0; i < SUM_BYTES; i++) begin
			sum = sum + head_pkt.bytes[i];
		end
	end

	assign lead_ok = (head_pkt.bytes[0] == 8'd7) || (head_pkt.bytes[0] == 8'd9);
	assign mant    = {head_pkt.bytes[4], head_pkt.bytes[5]};

	always_comb begin
		case (head_pkt.bytes[3][5:4])
			2'd0:    ival = 5'd6;
			2'd1:    ival = 5'd12;
			2'd2:    ival = 5'd18;
			default: ival = 5'd0;
		endcase
	end

	always_comb begin
		res_s1_next.checksum_ok     = head_pkt.full_count && (sum == head_pkt.bytes[7])
		                              && lead_ok;
		res_s1_next.transmitter_id  = {head_pkt.bytes[1], head_pkt.bytes[2]};
		res_s1_next.current_ma      = '0;
		res_s1_next.current_invalid = 1'b0;
		res_s1_next.power_w         = '0;
		res_s1_next.interval_s      = ival;
		res_s1_next.pairing_on      = head_pkt.bytes[3][7];
		res_s1_next.battery_ok      = head_pkt.bytes[3][6];
	end

	// stage 2: scale by exponent, range check
	assign shamt   = 4'(EXPO_MAX) - expo_s1[3:0];
	assign cur_raw = prod1_s1 >> shamt;
	assign cur_bad = (expo_s1 > 8'(EXPO_MAX)) || (cur_raw > 26'(CUR_MAX));

	always_comb begin
		res_s2_next                 = res_s1;
		res_s2_next.current_ma      = cur_bad ? 17'd0 : cur_raw[16:0];
		res_s2_next.current_invalid = cur_bad;
	end

	// stage 4: divide by 1000 as >>3 then times reciprocal of 125
	assign div8 = prod2_s3[26:3];

	always_comb begin
		res_q_next         = res_s4;
		res_q_next.power_w = prod3_s4[RECIP_SH+16:RECIP_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s1   <= res_s1_next;
			prod1_s1 <= 26'(mant) * 26'(MILLI);
			expo_s1  <= head_pkt.bytes[6];

			res_s2   <= res_s2_next;

			res_s3   <= res_s2;
			prod2_s3 <= 27'(res_s2.current_ma) * 27'(mains_v);

			res_s4   <= res_s3;
			prod3_s4 <= 49'(div8) * 49'(RECIP_125);

			res_q    <= res_q_next;
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.current_invalid |-> (res_q.current_ma == 17'd0)
		&& (res_q.power_w == 17'd0))
		else $error("flagged current not zeroed");

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.current_ma <= 17'(CUR_MAX)))
		else $error("current above limit");

endmodule
